// ===== rtl/hsv_pkg.sv =====
// hsv_pkg: shared types, constants and a helper function for the HSV to RGB converter.
// Used by hsv_level, hsv_to_rgb_converter and the checker. No dependencies.
`default_nettype none
package hsv_pkg;

  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned FULL_SCALE = 255;
  localparam int unsigned Q_SCALE    = SECTOR_DEG * FULL_SCALE;

  // Reciprocal of 255 at 2^-24 and of 3825 (Q_SCALE / 4) at 2^-32, rounded up.
  localparam logic [16:0] RECIP_P = 17'd65794;
  localparam int unsigned SHIFT_P = 24;
  localparam logic [20:0] RECIP_Q = 21'd1122868;
  localparam int unsigned SHIFT_Q = 32;

  // Cycles from an input transfer to its result strobe.
  localparam int unsigned LATENCY = 5;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } hsv_sector_t;

  typedef struct packed {
    logic        vld;
    hsv_sector_t sector;
    logic [7:0]  v;
  } hsv_tag_t;

  typedef struct packed {
    hsv_sector_t sector;
    logic [5:0]  rem;
  } hsv_split_t;

  function automatic hsv_split_t hue_split(input logic [8:0] hue);
    logic [3:0] k;
    logic [8:0] base;
    hsv_split_t res;
    k = 4'(hue >= 9'd60) + 4'(hue >= 9'd120) + 4'(hue >= 9'd180) + 4'(hue >= 9'd240)
      + 4'(hue >= 9'd300) + 4'(hue >= 9'd360) + 4'(hue >= 9'd420) + 4'(hue >= 9'd480);
    base = 9'(32'(k) * SECTOR_DEG);
    res.rem = 6'(hue - base);
    res.sector = (k > 4'd5) ? SEC_5 : hsv_sector_t'(k[2:0]);
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hsv_to_rgb_converter.sv =====
// hsv_to_rgb_converter: pipelined HSV to RGB pixel converter, top level.
// Depends on hsv_pkg and hsv_level.
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+-------------------------------
//   input    | hue, saturation, brightness    | start high, busy low at edge
//   result   | red, green, blue               | done high for one cycle
//
// One pixel per cycle; each result is registered at the input, in the hsv_level stages and at the output.
// busy stays low: every stage advances each cycle and there is no feedback.
// Synchronous reset drops all items in flight; no results follow it.
// The receiver cannot stall, so no stage ever holds.
`default_nettype none
module hsv_to_rgb_converter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [8:0] hue,
  input  wire logic [7:0] saturation,
  input  wire logic [7:0] brightness,
  output logic            done,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue
);

  hsv_pkg::hsv_tag_t   tag1, tag_lv;
  logic [5:0]          rem1;
  logic [7:0]          s1;
  hsv_pkg::hsv_split_t split;
  logic [7:0]          p, q, t;
  logic [7:0]          red_next, green_next, blue_next;
  logic                done_q;
  logic [7:0]          red_q, green_q, blue_q;

  assign busy  = 1'b0;
  assign split = hsv_pkg::hue_split(hue);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.vld <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      tag1.vld <= start && !busy;
      done_q   <= tag_lv.vld;
    end

    tag1.sector <= split.sector;
    tag1.v      <= brightness;
    rem1        <= split.rem;
    s1          <= saturation;
    red_q       <= red_next;
    green_q     <= green_next;
    blue_q      <= blue_next;
  end

  hsv_level u_level (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag1),
    .rem     (rem1),
    .s       (s1),
    .tag_out (tag_lv),
    .p       (p),
    .q       (q),
    .t       (t)
  );

  always_comb begin
    unique case (tag_lv.sector)
      hsv_pkg::SEC_0: begin
        red_next = tag_lv.v; green_next = t;        blue_next = p;
      end
      hsv_pkg::SEC_1: begin
        red_next = q;        green_next = tag_lv.v; blue_next = p;
      end
      hsv_pkg::SEC_2: begin
        red_next = p;        green_next = tag_lv.v; blue_next = t;
      end
      hsv_pkg::SEC_3: begin
        red_next = p;        green_next = q;        blue_next = tag_lv.v;
      end
      hsv_pkg::SEC_4: begin
        red_next = t;        green_next = p;        blue_next = tag_lv.v;
      end
      default: begin
        red_next = tag_lv.v; green_next = p;        blue_next = q;
      end
    endcase
  end

  assign done  = done_q;
  assign red   = red_q;
  assign green = green_q;
  assign blue  = blue_q;

endmodule
`default_nettype wire

// ===== rtl/hsv_level.sv =====
// hsv_level: three-stage datapath that forms the p, q and t levels of one pixel.
// Depends on hsv_pkg; carries the sector and value tag alongside the data.
`default_nettype none
module hsv_level (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hsv_pkg::hsv_tag_t tag_in,
  input  wire logic [5:0]       rem,
  input  wire logic [7:0]       s,
  output hsv_pkg::hsv_tag_t     tag_out,
  output logic [7:0]            p,
  output logic [7:0]            q,
  output logic [7:0]            t
);

  hsv_pkg::hsv_tag_t tag2, tag3, tag4;
  logic [7:0]  np2;
  logic [13:0] nq2, nt2;
  logic [15:0] pp3;
  logic [21:0] pq3, pt3;
  logic [7:0]  p4, q4, t4;

  logic [13:0] sr, srt;
  logic [5:0]  rem_c;
  logic [32:0] mp;
  logic [40:0] mq, mt;

  assign rem_c = 6'(hsv_pkg::SECTOR_DEG) - rem;
  assign sr    = 14'(s) * 14'(rem);
  assign srt   = 14'(s) * 14'(rem_c);

  assign mp = 33'(pp3) * 33'(hsv_pkg::RECIP_P);
  assign mq = 41'(pq3[21:2]) * 41'(hsv_pkg::RECIP_Q);
  assign mt = 41'(pt3[21:2]) * 41'(hsv_pkg::RECIP_Q);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2.vld <= 1'b0;
      tag3.vld <= 1'b0;
      tag4.vld <= 1'b0;
    end else begin
      tag2.vld <= tag_in.vld;
      tag3.vld <= tag2.vld;
      tag4.vld <= tag3.vld;
    end

    tag2.sector <= tag_in.sector;
    tag2.v      <= tag_in.v;
    np2         <= 8'(hsv_pkg::FULL_SCALE) - s;
    nq2         <= 14'(hsv_pkg::Q_SCALE) - sr;
    nt2         <= 14'(hsv_pkg::Q_SCALE) - srt;

    tag3.sector <= tag2.sector;
    tag3.v      <= tag2.v;
    pp3         <= 16'(tag2.v) * 16'(np2);
    pq3         <= 22'(tag2.v) * 22'(nq2);
    pt3         <= 22'(tag2.v) * 22'(nt2);

    tag4.sector <= tag3.sector;
    tag4.v      <= tag3.v;
    p4          <= mp[hsv_pkg::SHIFT_P +: 8];
    q4          <= mq[hsv_pkg::SHIFT_Q +: 8];
    t4          <= mt[hsv_pkg::SHIFT_Q +: 8];
  end

  assign tag_out = tag4;
  assign p       = p4;
  assign q       = q4;
  assign t       = t4;

endmodule
`default_nettype wire

// ===== rtl/hsv_checker.sv =====
// hsv_checker: port-level assertions for hsv_to_rgb_converter, bound to the top level.
// Depends on hsv_pkg for the pipeline latency.
`default_nettype none
module hsv_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [7:0] saturation,
  input wire logic [7:0] brightness,
  input wire logic       done,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue
);

  a_busy_low: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_from_transfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, hsv_pkg::LATENCY))
    else $error("result without a matching transfer");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    done && $past(saturation == 8'd0, hsv_pkg::LATENCY) |->
      red == $past(brightness, hsv_pkg::LATENCY) && green == red && blue == red)
    else $error("zero saturation is not grey");

  a_max_is_value: assert property (@(posedge clk) disable iff (rst)
    done |-> red == $past(brightness, hsv_pkg::LATENCY)
          || green == $past(brightness, hsv_pkg::LATENCY)
          || blue == $past(brightness, hsv_pkg::LATENCY))
    else $error("no channel equals value");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .saturation (saturation),
  .brightness (brightness),
  .done       (done),
  .red        (red),
  .green      (green),
  .blue       (blue)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for hsv_to_rgb_converter, fed with directed and random pixels.
// Predicts red, green and blue per transfer and compares each done strobe in order.
// Depends on hsv_pkg and the converter RTL.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [8:0]  hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    int unsigned idle_pct;
  } pixel_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [8:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;
  logic       done;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  pixel_t pixel_queue[$];
  rgb_t   rgb_due[$];
  pixel_t shown;
  int     errors;

  hsv_to_rgb_converter dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always #5 clk = ~clk;

  function automatic rgb_t convert_pixel(pixel_t px);
    int unsigned h;
    int unsigned s;
    int unsigned v;
    int unsigned rem;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    hsv_pkg::hsv_sector_t sec;
    rgb_t res;
    h = px.hue;
    s = px.sat;
    v = px.val;
    rem = h % hsv_pkg::SECTOR_DEG;
    sec = (h / hsv_pkg::SECTOR_DEG > 5) ? hsv_pkg::SEC_5
        : hsv_pkg::hsv_sector_t'(3'(h / hsv_pkg::SECTOR_DEG));
    p = (v * (hsv_pkg::FULL_SCALE - s)) / hsv_pkg::FULL_SCALE;
    q = (v * (hsv_pkg::Q_SCALE - s * rem)) / hsv_pkg::Q_SCALE;
    t = (v * (hsv_pkg::Q_SCALE - s * (hsv_pkg::SECTOR_DEG - rem))) / hsv_pkg::Q_SCALE;
    case (sec)
      hsv_pkg::SEC_0: begin res.red = 8'(v); res.green = 8'(t); res.blue = 8'(p); end
      hsv_pkg::SEC_1: begin res.red = 8'(q); res.green = 8'(v); res.blue = 8'(p); end
      hsv_pkg::SEC_2: begin res.red = 8'(p); res.green = 8'(v); res.blue = 8'(t); end
      hsv_pkg::SEC_3: begin res.red = 8'(p); res.green = 8'(q); res.blue = 8'(v); end
      hsv_pkg::SEC_4: begin res.red = 8'(t); res.green = 8'(p); res.blue = 8'(v); end
      default: begin res.red = 8'(v); res.green = 8'(p); res.blue = 8'(q); end
    endcase
    return res;
  endfunction

  task automatic add_pixel(int unsigned h, int unsigned s, int unsigned v, int unsigned pct);
    pixel_t px;
    px.hue = 9'(h);
    px.sat = 8'(s);
    px.val = 8'(v);
    px.idle_pct = pct;
    pixel_queue.push_back(px);
  endtask

  function automatic int unsigned pick_level();
    case ($urandom_range(9))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: present the next pixel, or random noise with start low while idle.
  always @(posedge clk) begin
    logic hold;
    if (rst) begin
      start <= 1'b0;
    end else begin
      hold = start && busy;
      if (start && !busy) begin
        rgb_due.push_back(convert_pixel(shown));
      end
      if (!hold) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= pixel_queue[0].idle_pct) begin
          shown = pixel_queue.pop_front();
          start      <= 1'b1;
          hue        <= shown.hue;
          saturation <= shown.sat;
          brightness <= shown.val;
        end else begin
          start      <= 1'b0;
          hue        <= 9'($urandom);
          saturation <= 8'($urandom);
          brightness <= 8'($urandom);
        end
      end
    end
  end

  // Monitor: match each strobe against the oldest transfer.
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && done) begin
      if (rgb_due.size() == 0) begin
        $display("%0t: result with no transfer pending: r=%0d g=%0d b=%0d",
                 $time, red, green, blue);
        errors++;
      end else begin
        want = rgb_due.pop_front();
        check_channel("red", want.red, red);
        check_channel("green", want.green, green);
        check_channel("blue", want.blue, blue);
      end
    end
  end

  initial begin
    int unsigned phase_pct[4];
    int unsigned h;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    hue = '0;
    saturation = '0;
    brightness = '0;
    errors = 0;
    phase_pct = '{0, 65, 0, 13};

    foreach (phase_pct[i]) begin
      if (i == 0) begin
        add_pixel(0, 255, 255, 0);
        add_pixel(59, 255, 255, 0);
        add_pixel(60, 255, 255, 0);
        add_pixel(119, 255, 255, 0);
        add_pixel(120, 255, 255, 0);
        add_pixel(179, 255, 255, 0);
        add_pixel(180, 255, 255, 0);
        add_pixel(239, 255, 255, 0);
        add_pixel(240, 255, 255, 0);
        add_pixel(299, 255, 255, 0);
        add_pixel(300, 255, 255, 0);
        add_pixel(359, 255, 255, 0);
        add_pixel(360, 255, 255, 0);
        add_pixel(420, 200, 255, 0);
        add_pixel(480, 255, 128, 0);
        add_pixel(511, 255, 255, 0);
        add_pixel(30, 0, 255, 0);
        add_pixel(200, 0, 77, 0);
        add_pixel(90, 255, 0, 0);
        add_pixel(0, 0, 0, 0);
        add_pixel(511, 0, 0, 0);
        add_pixel(359, 128, 200, 0);
      end
      repeat (185) begin
        h = ($urandom_range(7) == 0) ? $urandom_range(511, 360) : $urandom_range(359);
        add_pixel(h, pick_level(), pick_level(), phase_pct[i]);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pixel_queue.size() != 0 || start) @(posedge clk);
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (2 * hsv_pkg::LATENCY + 4) @(posedge clk);

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
